>>> rtl/nsr_pkg.sv
// shared types and constants for the nav slot insert-or-refresh block
`default_nettype none

package nsr_pkg;

  localparam logic [3:0]  KIND_FREE     = 4'hF;
  localparam logic [31:0] REF_SKIP      = 32'hFFFF_FFFF;
  localparam logic [15:0] MARKER_SKIP   = 16'hFFFF;

  localparam logic [1:0]  OUT_UNTOUCHED = 2'd0;
  localparam logic [1:0]  OUT_REFRESHED = 2'd1;
  localparam logic [1:0]  OUT_PLACED    = 2'd2;
  localparam logic [1:0]  OUT_FULL      = 2'd3;

  typedef struct packed {
    logic signed [3:0]  kind;
    logic signed [31:0] reference;
    logic signed [15:0] marker;
    logic [31:0]        height;
  } nsr_req_t;

  typedef struct packed {
    logic serve;   // player present and request not skipped
    logic commit;  // beat leaves the input stage this cycle
  } nsr_ctl_t;

  typedef struct packed {
    logic [1:0] outcome;
    logic [1:0] slot;
  } nsr_res_t;

endpackage

`default_nettype wire

>>> rtl/nsr_player_table.sv
// one player's slot table with parallel lookup and registered update
`default_nettype none

module nsr_player_table
  import nsr_pkg::*;
#(
  parameter int SLOTS = 4
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire nsr_req_t req,
  input  wire nsr_ctl_t ctl,
  output nsr_res_t      res
);

  localparam int SIDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  logic [3:0]  kind_r   [SLOTS];
  logic [31:0] ref_r    [SLOTS];
  logic [15:0] marker_r [SLOTS];
  logic [31:0] height_r [SLOTS];

  logic [SLOTS-1:0]  match;
  logic [SLOTS-1:0]  free;
  logic              hit;
  logic              any_free;
  logic [SIDX_W-1:0] hit_idx;
  logic [SIDX_W-1:0] free_idx;
  logic [SIDX_W-1:0] sel_idx;
  logic [SIDX_W+1:0] sel_ext;

  always_comb begin
    for (int s = 0; s < SLOTS; s++) begin
      match[s] = (kind_r[s] == req.kind) && (ref_r[s] == req.reference);
      free[s]  = (kind_r[s] == KIND_FREE);
    end
    // lowest matching slot wins
    hit     = 1'b0;
    hit_idx = '0;
    for (int s = SLOTS - 1; s >= 0; s--) begin
      if (match[s]) begin
        hit     = 1'b1;
        hit_idx = SIDX_W'(s);
      end
    end
    // highest free slot wins
    any_free = 1'b0;
    free_idx = '0;
    for (int s = 0; s < SLOTS; s++) begin
      if (free[s]) begin
        any_free = 1'b1;
        free_idx = SIDX_W'(s);
      end
    end
    sel_idx = hit ? hit_idx : free_idx;
    sel_ext = {2'b00, sel_idx};
    if (!ctl.serve) begin
      res.outcome = OUT_UNTOUCHED;
      res.slot    = 2'd0;
    end else if (hit) begin
      res.outcome = OUT_REFRESHED;
      res.slot    = sel_ext[1:0];
    end else if (any_free) begin
      res.outcome = OUT_PLACED;
      res.slot    = sel_ext[1:0];
    end else begin
      res.outcome = OUT_FULL;
      res.slot    = 2'd0;
    end
  end

  // kind and reference take part in lookup, so they reset
  always_ff @(posedge clk) begin
    for (int s = 0; s < SLOTS; s++) begin
      if (!rst_n) begin
        kind_r[s] <= KIND_FREE;
        ref_r[s]  <= '0;
      end else if (ctl.serve && ctl.commit && !hit && any_free &&
                   (free_idx == SIDX_W'(s))) begin
        kind_r[s] <= req.kind;
        ref_r[s]  <= req.reference;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < SLOTS; s++) begin
      if (ctl.serve && ctl.commit && (hit || any_free) &&
          (sel_idx == SIDX_W'(s))) begin
        marker_r[s] <= req.marker;
        height_r[s] <= req.height;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/nav_slot_insert_or_refresh.sv
// top level: nav slot insert-or-refresh for two local players
// an accepted beat passes the input register and then the result register to out_valid; out_stall can hold it
// throughput: one beat per cycle while out_stall is low, with combinational table lookup and registered update
// the table update happens as a beat leaves the input register, so the next beat sees it
// reset (synchronous, rst_n low): all slots free with reference zero, both stages empty
`default_nettype none

module nav_slot_insert_or_refresh
  import nsr_pkg::*;
#(
  parameter int SLOTS_PER_PLAYER = 4
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  // input channel
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         in_present_mask,
  input  wire logic signed [3:0]  in_point_kind,
  input  wire logic signed [31:0] in_target_reference,
  input  wire logic signed [15:0] in_marker_index,
  input  wire logic [31:0]        in_height_bits,
  // result channel
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [1:0]              out_outcome_zero,
  output logic [1:0]              out_slot_zero,
  output logic [1:0]              out_outcome_one,
  output logic [1:0]              out_slot_one
);

  // input register stage
  logic       s1_valid_r;
  logic [1:0] s1_mask_r;
  nsr_req_t   s1_req_r;

  // result register stage
  logic       out_valid_r;
  nsr_res_t   res0_r;
  nsr_res_t   res1_r;

  logic       move;      // beat goes from input stage to result stage
  logic       req_ok;    // neither reference nor marker is the skip code
  nsr_ctl_t   ctl0;
  nsr_ctl_t   ctl1;
  nsr_res_t   res0;
  nsr_res_t   res1;

  // result stage frees up when empty or being drained this cycle
  assign move     = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !move;

  assign req_ok = (s1_req_r.reference != REF_SKIP) && (s1_req_r.marker != MARKER_SKIP);

  assign ctl0.serve  = s1_mask_r[0] && req_ok;
  assign ctl0.commit = move;
  assign ctl1.serve  = s1_mask_r[1] && req_ok;
  assign ctl1.commit = move;

  // input register: loads whenever it is empty or its beat moves on
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_mask_r          <= in_present_mask;
      s1_req_r.kind      <= in_point_kind;
      s1_req_r.reference <= in_target_reference;
      s1_req_r.marker    <= in_marker_index;
      s1_req_r.height    <= in_height_bits;
    end
  end

  // player 0 owns its own table, player 1 likewise
  nsr_player_table #(
    .SLOTS (SLOTS_PER_PLAYER)
  ) u_table0 (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (s1_req_r),
    .ctl   (ctl0),
    .res   (res0)
  );

  nsr_player_table #(
    .SLOTS (SLOTS_PER_PLAYER)
  ) u_table1 (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (s1_req_r),
    .ctl   (ctl1),
    .res   (res1)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (move) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      res0_r <= res0;
      res1_r <= res1;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_outcome_zero = res0_r.outcome;
  assign out_slot_zero    = res0_r.slot;
  assign out_outcome_one  = res1_r.outcome;
  assign out_slot_one     = res1_r.slot;

  // a beat that moves always shows up as a result next cycle
  a_move_fills_output : assert property (@(posedge clk) disable iff (!rst_n)
    move |=> out_valid_r)
    else $error("moved beat did not reach the result stage");

  // a skipped request leaves both players untouched
  a_skip_untouched : assert property (@(posedge clk) disable iff (!rst_n)
    (move && !req_ok) |=> (res0_r.outcome == OUT_UNTOUCHED &&
                           res1_r.outcome == OUT_UNTOUCHED))
    else $error("skipped request changed an outcome");

  // absent player 0 gets no outcome
  a_absent_untouched : assert property (@(posedge clk) disable iff (!rst_n)
    (move && !s1_mask_r[0]) |=> (res0_r.outcome == OUT_UNTOUCHED && res0_r.slot == 2'd0))
    else $error("absent player 0 reported an outcome");

  // player 1's untouched or full results carry slot zero
  a_slot_zero_when_idle : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (res1_r.outcome == OUT_UNTOUCHED || res1_r.outcome == OUT_FULL))
      |-> (res1_r.slot == 2'd0))
    else $error("player 1 slot nonzero without a write");

endmodule

`default_nettype wire

>>> bench/tb_nav_slot_insert_or_refresh.sv
// self-checking bench for the two-player nav slot insert-or-refresh block
`default_nettype none

module tb_nav_slot_insert_or_refresh;
  import nsr_pkg::*;

  localparam int SLOTS      = 4;
  localparam int PLAYERS    = 2;
  localparam int RAND_BEATS = 1035;
  localparam int CYCLE_CAP  = 500000;
  localparam int DRAIN_WAIT = 12;
  localparam int LONG_HOLD  = 200;

  // one request as the sender keeps it; drain_first holds it back until every result is in
  typedef struct {
    logic [1:0] mask;
    nsr_req_t   req;
    bit         drain_first;
  } nav_beat_t;

  typedef struct packed {
    nsr_res_t zero;
    nsr_res_t one;
  } nav_result_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [1:0]         in_present_mask;
  logic signed [3:0]  in_point_kind;
  logic signed [31:0] in_target_reference;
  logic signed [15:0] in_marker_index;
  logic [31:0]        in_height_bits;
  logic               out_valid;
  logic               out_stall;
  logic [1:0]         out_outcome_zero;
  logic [1:0]         out_slot_zero;
  logic [1:0]         out_outcome_one;
  logic [1:0]         out_slot_one;

  nav_slot_insert_or_refresh #(
    .SLOTS_PER_PLAYER(SLOTS)
  ) u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_present_mask    (in_present_mask),
    .in_point_kind      (in_point_kind),
    .in_target_reference(in_target_reference),
    .in_marker_index    (in_marker_index),
    .in_height_bits     (in_height_bits),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_outcome_zero   (out_outcome_zero),
    .out_slot_zero      (out_slot_zero),
    .out_outcome_one    (out_outcome_one),
    .out_slot_one       (out_slot_one)
  );

  // bench copy of both players' slot tables
  logic [3:0]  tbl_kind   [PLAYERS][SLOTS];
  logic [31:0] tbl_ref    [PLAYERS][SLOTS];
  logic [15:0] tbl_marker [PLAYERS][SLOTS];
  logic [31:0] tbl_height [PLAYERS][SLOTS];

  nav_beat_t   pending_beats[$];     // requests not yet offered to the block
  nav_result_t slot_results_due[$];  // predicted outcomes, oldest first

  int total_beats;
  int accepted_beats;
  int checked_results;
  int errors;
  int cycle_count;
  int gap_left;
  int stall_left;
  int stall_pick;
  bit long_hold_done;
  int outcome_seen[4];

  // clock
  always #5 clk = ~clk;

  // hard stop in case the block hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_CAP) begin
      $display("timeout after %0d cycles, %0d results still due", cycle_count,
               slot_results_due.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  // idle length for either side: mostly none, some short, a few long;
  // every fourth window of the cycle count runs with no idling at all
  function automatic int pick_idle();
    int r;
    if ((cycle_count / 300) % 4 == 1) return 0;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // one player's lookup: lowest matching slot is refreshed, else the
  // highest free slot is filled, else the table is full
  function automatic nsr_res_t serve_player(int p, bit present, nsr_req_t rq);
    nsr_res_t r;
    int       free_at;
    r.outcome = OUT_UNTOUCHED;
    r.slot    = 2'd0;
    free_at   = -1;
    if (!present) return r;
    if (rq.reference == REF_SKIP || rq.marker == MARKER_SKIP) return r;
    for (int s = 0; s < SLOTS; s++) begin
      if (tbl_kind[p][s] == rq.kind && tbl_ref[p][s] == rq.reference) begin
        tbl_height[p][s] = rq.height;
        tbl_marker[p][s] = rq.marker;
        r.outcome = OUT_REFRESHED;
        r.slot    = 2'(s);
        return r;
      end
      if (tbl_kind[p][s] == KIND_FREE) free_at = s;
    end
    if (free_at < 0) begin
      r.outcome = OUT_FULL;
      return r;
    end
    // a free-kind request placed here leaves the slot free, with a new reference
    tbl_kind[p][free_at]   = rq.kind;
    tbl_ref[p][free_at]    = rq.reference;
    tbl_marker[p][free_at] = rq.marker;
    tbl_height[p][free_at] = rq.height;
    r.outcome = OUT_PLACED;
    r.slot    = 2'(free_at);
    return r;
  endfunction

  task automatic add_beat(input logic [1:0] mask, input logic [3:0] kind,
                          input logic [31:0] target, input logic [15:0] marker,
                          input logic [31:0] height, input bit drain_first);
    nav_beat_t b;
    b.mask          = mask;
    b.req.kind      = kind;
    b.req.reference = target;
    b.req.marker    = marker;
    b.req.height    = height;
    b.drain_first   = drain_first;
    pending_beats.push_back(b);
    total_beats++;
  endtask

  // random request: a small reference pool and few kinds so that refreshes
  // and placements keep landing, with full-range values mixed in
  task automatic add_random_beat(input bit drain_first);
    logic [3:0]  kind;
    logic [31:0] target;
    logic [15:0] marker;
    int          r;
    r = $urandom_range(0, 99);
    if (r < 40) kind = KIND_FREE;
    else if (r < 80) begin
      case ($urandom_range(0, 3))
        0:       kind = 4'sd0;
        1:       kind = 4'sd7;
        2:       kind = -4'sd8;
        default: kind = 4'sd2;
      endcase
    end else kind = 4'($urandom);
    r = $urandom_range(0, 99);
    if (r < 5) target = REF_SKIP;
    else if (r < 75) begin
      case ($urandom_range(0, 5))
        0:       target = 32'h0000_0000;
        1:       target = 32'h0000_0100;
        2:       target = 32'h0000_0055;
        3:       target = 32'h7FFF_FFFF;
        4:       target = 32'h8000_0000;
        default: target = 32'h0000_0010;
      endcase
    end else target = $urandom;
    marker = ($urandom_range(0, 99) < 5) ? MARKER_SKIP : 16'($urandom);
    add_beat(2'($urandom_range(0, 3)), kind, target, marker, $urandom, drain_first);
  endtask

  // sender: predicts at the accepting edge, then offers the next beat
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        nav_result_t   res;
        nsr_req_t      rq;
        rq.kind      = in_point_kind;
        rq.reference = in_target_reference;
        rq.marker    = in_marker_index;
        rq.height    = in_height_bits;
        res.zero     = serve_player(0, in_present_mask[0], rq);
        res.one      = serve_player(1, in_present_mask[1], rq);
        slot_results_due.push_back(res);
        accepted_beats++;
      end
      // the payload only moves once the current beat is gone
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (pending_beats.size() > 0 &&
                     !(pending_beats[0].drain_first && slot_results_due.size() > 0)) begin
          nav_beat_t b;
          b = pending_beats.pop_front();
          in_present_mask     <= b.mask;
          in_point_kind       <= b.req.kind;
          in_target_reference <= b.req.reference;
          in_marker_index     <= b.req.marker;
          in_height_bits      <= b.req.height;
          in_valid            <= 1'b1;
          gap_left            <= pick_idle();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: checks each result beat, then decides the next stall
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        nav_result_t want;
        if (slot_results_due.size() == 0) begin
          $display("%0t: result beat with nothing due: outcome0=%0d slot0=%0d outcome1=%0d slot1=%0d",
                   $time, out_outcome_zero, out_slot_zero, out_outcome_one, out_slot_one);
          errors++;
        end else begin
          want = slot_results_due.pop_front();
          checked_results++;
          outcome_seen[out_outcome_zero]++;
          outcome_seen[out_outcome_one]++;
          if (out_outcome_zero !== want.zero.outcome) begin
            $display("%0t: outcome_zero expected %0d got %0d", $time,
                     want.zero.outcome, out_outcome_zero);
            errors++;
          end
          if (out_slot_zero !== want.zero.slot) begin
            $display("%0t: slot_zero expected %0d got %0d", $time,
                     want.zero.slot, out_slot_zero);
            errors++;
          end
          if (out_outcome_one !== want.one.outcome) begin
            $display("%0t: outcome_one expected %0d got %0d", $time,
                     want.one.outcome, out_outcome_one);
            errors++;
          end
          if (out_slot_one !== want.one.slot) begin
            $display("%0t: slot_one expected %0d got %0d", $time,
                     want.one.slot, out_slot_one);
            errors++;
          end
        end
      end
      // one long hold mid-run so the block backs up into in_stall
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_stall  <= 1'b1;
      end else if (!long_hold_done && accepted_beats >= 400) begin
        long_hold_done <= 1'b1;
        stall_left     <= LONG_HOLD - 1;
        out_stall      <= 1'b1;
      end else begin
        stall_pick = pick_idle();
        out_stall  <= (stall_pick != 0);
        stall_left <= (stall_pick == 0) ? 0 : stall_pick - 1;
      end
    end
  end

  initial begin
    clk                 = 1'b0;
    rst_n               = 1'b0;
    in_valid            = 1'b0;
    in_present_mask     = '0;
    in_point_kind       = '0;
    in_target_reference = '0;
    in_marker_index     = '0;
    in_height_bits      = '0;
    out_stall           = 1'b0;
    total_beats         = 0;
    accepted_beats      = 0;
    checked_results     = 0;
    errors              = 0;
    cycle_count         = 0;
    gap_left            = 0;
    stall_left          = 0;
    long_hold_done      = 1'b0;
    outcome_seen        = '{default: 0};
    for (int p = 0; p < PLAYERS; p++) begin
      for (int s = 0; s < SLOTS; s++) begin
        tbl_kind[p][s]   = KIND_FREE;
        tbl_ref[p][s]    = '0;
        tbl_marker[p][s] = '0;
        tbl_height[p][s] = '0;
      end
    end

    // directed: placement in the top free slot for both players, then a refresh
    add_beat(2'b11, 4'sd0, 32'h0000_0100, 16'h0000, 32'h0000_0000, 1'b0);
    add_beat(2'b11, 4'sd0, 32'h0000_0100, 16'h0005, 32'hFFFF_FFFF, 1'b0);
    // field extremes, one player at a time
    add_beat(2'b01, 4'sd7, 32'h7FFF_FFFF, 16'h7FFF, 32'h3F80_0000, 1'b0);
    add_beat(2'b10, -4'sd8, 32'h8000_0000, 16'h8000, 32'hFFFF_FFFF, 1'b0);
    // nobody present
    add_beat(2'b00, 4'sd1, 32'h0000_0005, 16'h0001, 32'h1234_5678, 1'b0);
    // skipped reference, skipped marker
    add_beat(2'b11, 4'sd3, REF_SKIP, 16'h0002, 32'h0000_0001, 1'b0);
    add_beat(2'b11, 4'sd3, 32'h0000_0200, MARKER_SKIP, 32'h0000_0001, 1'b0);
    // free kind: placed slot stays free, a repeat then refreshes it
    add_beat(2'b10, KIND_FREE, 32'h0000_0055, 16'h0010, 32'hAAAA_5555, 1'b0);
    add_beat(2'b10, KIND_FREE, 32'h0000_0055, 16'h0011, 32'h5555_AAAA, 1'b0);
    // free kind with reference zero matches an untouched slot from reset
    add_beat(2'b01, KIND_FREE, 32'h0000_0000, 16'h0012, 32'h0000_0002, 1'b0);
    // fill player 0 until the table is full
    add_beat(2'b01, 4'sd2, 32'h0000_0010, 16'h0020, 32'h0000_0003, 1'b0);
    add_beat(2'b01, 4'sd2, 32'h0000_0011, 16'h0021, 32'h0000_0004, 1'b0);
    add_beat(2'b01, 4'sd2, 32'h0000_0012, 16'h0022, 32'h0000_0005, 1'b0);
    add_beat(2'b11, 4'sd2, 32'h0000_0013, 16'hFFFE, 32'h0000_0006, 1'b0);
    // refresh still works on a full table
    add_beat(2'b01, 4'sd0, 32'h0000_0100, 16'h0030, 32'h0000_0007, 1'b0);
    add_beat(2'b11, 4'sd3, 32'h0000_0000, 16'h0001, 32'h3F80_0000, 1'b0);

    // random part; the first random beat and one mid-way wait until everything before them is out
    for (int i = 0; i < RAND_BEATS; i++) add_random_beat(i == 0 || i == 600);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // sampled on the falling edge to stay clear of the clocked processes
    do @(negedge clk);
    while (accepted_beats < total_beats || slot_results_due.size() > 0);
    repeat (DRAIN_WAIT) @(negedge clk);

    $display("%0d request beats, %0d result beats checked, %0d mismatches", accepted_beats,
             checked_results, errors);
    $display("player outcomes seen: untouched %0d, refreshed %0d, placed %0d, full %0d",
             outcome_seen[OUT_UNTOUCHED], outcome_seen[OUT_REFRESHED],
             outcome_seen[OUT_PLACED], outcome_seen[OUT_FULL]);
    if (errors == 0 && slot_results_due.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> sim.f
rtl/nsr_pkg.sv
rtl/nsr_player_table.sv
rtl/nav_slot_insert_or_refresh.sv
bench/tb_nav_slot_insert_or_refresh.sv
